// ----- rtl/efd_pkg.sv -----
package efd_pkg;

  // Link symbols
  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;
  localparam logic [7:0] SYM_ESC = 8'h10;
  localparam logic [7:0] SYM_ETB = 8'h17;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_HDR   = 3'd1;
  localparam logic [2:0] ST_BAD_ESC   = 3'd2;
  localparam logic [2:0] ST_BAD_FOOT  = 3'd3;
  localparam logic [2:0] ST_BAD_TERM  = 3'd4;
  localparam logic [2:0] ST_BAD_CHECK = 3'd5;

  // One result item
  typedef struct packed {
    logic        is_frame_end;
    logic [7:0]  payload_byte;
    logic        last_block;
    logic [15:0] frame_length;
    logic [2:0]  status;
  } result_t;

endpackage

// ----- rtl/efd_parser.sv -----
module efd_parser
  import efd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] rx_byte,
  output logic       res_vld,
  output result_t    res
);

  localparam logic [3:0] PH_HUNT_ESC   = 4'd0;
  localparam logic [3:0] PH_HUNT_STX   = 4'd1;
  localparam logic [3:0] PH_HDR_A      = 4'd2;
  localparam logic [3:0] PH_HDR_B      = 4'd3;
  localparam logic [3:0] PH_LEN_LO     = 4'd4;
  localparam logic [3:0] PH_LEN_HI     = 4'd5;
  localparam logic [3:0] PH_PAYLOAD    = 4'd6;
  localparam logic [3:0] PH_FOOT_ESC   = 4'd7;
  localparam logic [3:0] PH_FOOT_TERM  = 4'd8;
  localparam logic [3:0] PH_FOOT_CHECK = 4'd9;

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [15:0] length_r, length_nxt;
  logic [7:0]  check_r, check_nxt;
  logic        esc_pend_r, esc_pend_nxt;
  logic        term_kind_r, term_kind_nxt;
  logic        clear;
  logic        emit_vld;

  // Decode one byte against the current frame phase
  always_comb begin
    phase_nxt          = phase_r;
    remaining_nxt      = remaining_r;
    length_nxt         = length_r;
    check_nxt          = check_r;
    esc_pend_nxt       = esc_pend_r;
    term_kind_nxt      = term_kind_r;
    clear              = 1'b0;
    emit_vld           = 1'b0;
    res.is_frame_end   = 1'b1;
    res.payload_byte   = 8'h00;
    res.last_block     = 1'b0;
    res.frame_length   = length_r;
    res.status         = ST_OK;
    unique case (phase_r)
      PH_HUNT_ESC: begin
        if (rx_byte != SYM_ESC) begin
          emit_vld   = 1'b1;
          res.status = ST_BAD_HDR;
          clear      = 1'b1;
        end else begin
          phase_nxt = PH_HUNT_STX;
        end
      end
      PH_HUNT_STX: begin
        if (rx_byte != SYM_STX) begin
          emit_vld   = 1'b1;
          res.status = ST_BAD_HDR;
          clear      = 1'b1;
        end else begin
          phase_nxt = PH_HDR_A;
        end
      end
      PH_HDR_A: begin
        check_nxt = check_r ^ rx_byte;
        phase_nxt = PH_HDR_B;
      end
      PH_HDR_B: begin
        check_nxt = check_r ^ rx_byte;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        check_nxt  = check_r ^ rx_byte;
        length_nxt = {8'h00, rx_byte};
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        check_nxt     = check_r ^ rx_byte;
        length_nxt    = {rx_byte, length_r[7:0]};
        remaining_nxt = {rx_byte, length_r[7:0]};
        phase_nxt     = ({rx_byte, length_r[7:0]} == 16'h0000) ? PH_FOOT_ESC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (esc_pend_r && rx_byte != SYM_ESC) begin
          emit_vld   = 1'b1;
          res.status = ST_BAD_ESC;
          clear      = 1'b1;
        end else if (!esc_pend_r && rx_byte == SYM_ESC) begin
          esc_pend_nxt = 1'b1;
        end else begin
          // Emit one unescaped payload byte
          emit_vld         = 1'b1;
          esc_pend_nxt     = 1'b0;
          res.is_frame_end = 1'b0;
          res.payload_byte = rx_byte;
          check_nxt        = check_r ^ rx_byte;
          remaining_nxt    = remaining_r - 16'd1;
          if (remaining_r == 16'd1) begin
            phase_nxt = PH_FOOT_ESC;
          end
        end
      end
      PH_FOOT_ESC: begin
        if (rx_byte != SYM_ESC) begin
          emit_vld   = 1'b1;
          res.status = ST_BAD_FOOT;
          clear      = 1'b1;
        end else begin
          phase_nxt = PH_FOOT_TERM;
        end
      end
      PH_FOOT_TERM: begin
        if (rx_byte == SYM_ETX || rx_byte == SYM_ETB) begin
          term_kind_nxt = (rx_byte == SYM_ETX);
          check_nxt     = check_r ^ rx_byte;
          phase_nxt     = PH_FOOT_CHECK;
        end else begin
          emit_vld   = 1'b1;
          res.status = ST_BAD_TERM;
          clear      = 1'b1;
        end
      end
      PH_FOOT_CHECK: begin
        emit_vld       = 1'b1;
        res.last_block = term_kind_r;
        res.status     = (rx_byte == check_r) ? ST_OK : ST_BAD_CHECK;
        clear          = 1'b1;
      end
      default: begin
        clear = 1'b1;
      end
    endcase
    // Drop all frame state after an end or error
    if (clear) begin
      phase_nxt     = PH_HUNT_ESC;
      remaining_nxt = 16'h0000;
      length_nxt    = 16'h0000;
      check_nxt     = 8'h00;
      esc_pend_nxt  = 1'b0;
      term_kind_nxt = 1'b0;
    end
  end

  assign res_vld = step_en && emit_vld;

  // Advance frame state on each processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT_ESC;
      remaining_r <= 16'h0000;
      length_r    <= 16'h0000;
      check_r     <= 8'h00;
      esc_pend_r  <= 1'b0;
      term_kind_r <= 1'b0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      length_r    <= length_nxt;
      check_r     <= check_nxt;
      esc_pend_r  <= esc_pend_nxt;
      term_kind_r <= term_kind_nxt;
    end
  end

  a_end_rehunts: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && res.is_frame_end |=> phase_r == PH_HUNT_ESC && check_r == 8'h00)
    else $error("frame state not cleared after end result");

  a_payload_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && !res.is_frame_end |-> phase_r == PH_PAYLOAD)
    else $error("payload result outside payload phase");

  a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remaining_r != 16'h0000)
    else $error("payload phase with no bytes left");

endmodule

// ----- rtl/efd_out_fifo.sv -----
module efd_out_fifo
  import efd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    has_room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;

  assign has_room  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem_r[rd_ptr_r];

  // Hold results until the receiver takes them
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/escaped_frame_deframer.sv -----
// Escaped-frame deframer: parses ESC STX framed link traffic one byte per cycle unless stalled.
// Input channel: in_valid / in_stall with in_rx_byte; a byte transfers at a
// rising edge where in_valid is high and in_stall is low.
// Output channel: out_valid / out_stall with one result per transfer: a payload
// byte (out_is_frame_end = 0) or an end-of-frame / error result carrying
// out_status, out_last_block and out_frame_length.
// Throughput: one byte per cycle while the result buffer has room, set by the frame parser.
// A transferred byte is held in the input register, then the parser writes its result
// into the two-entry result buffer, from which it is offered.
// Bytes without a result (header, escapes, footer) still take a parser step each.
// Reset (rst_n low, synchronous) empties both stages and puts the parser back
// to hunting for ESC STX.
// When the receiver stalls, up to two results wait in the buffer while one more
// byte sits in the input register; in_stall rises only once all are full.
module escaped_frame_deframer
  import efd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_is_frame_end,
  output logic [7:0]  out_payload_byte,
  output logic        out_last_block,
  output logic [15:0] out_frame_length,
  output logic [2:0]  out_status
);

  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       has_room;
  logic       step_en;
  logic       res_vld;
  result_t    res;
  result_t    out_data;

  assign step_en  = in_vld_r && has_room;
  assign in_stall = in_vld_r && !has_room;

  // Capture each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
  end

  efd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .rx_byte (in_byte_r),
    .res_vld (res_vld),
    .res     (res)
  );

  efd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_is_frame_end = out_data.is_frame_end;
  assign out_payload_byte = out_data.payload_byte;
  assign out_last_block   = out_data.last_block;
  assign out_frame_length = out_data.frame_length;
  assign out_status       = out_data.status;

endmodule

// ----- tb/sv/tb_escaped_frame_deframer.sv -----
module tb_escaped_frame_deframer;
  import efd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic [3:0] {
    P_HUNT_ESC, P_HUNT_STX, P_HDR_A, P_HDR_B, P_LEN_LO, P_LEN_HI,
    P_PAYLOAD, P_FOOT_ESC, P_FOOT_TERM, P_FOOT_CHECK
  } parse_phase_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_is_frame_end;
  logic [7:0]  out_payload_byte;
  logic        out_last_block;
  logic [15:0] out_frame_length;
  logic [2:0]  out_status;

  // Deframer state as the testbench tracks it
  parse_phase_e parse_phase;
  logic [15:0]  bytes_left;
  logic [15:0]  frame_len;
  logic [7:0]   xor_sum;
  logic         esc_seen;
  logic         ends_with_etx;

  result_t deframed_results[$];
  int      error_count;
  int      cycle_count;

  // Sender burst control and receiver hold-off
  int burst_left;
  bit idle_enable;
  int hold_request;
  int hold_left;
  int stall_pct;
  int stall_span;

  escaped_frame_deframer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_is_frame_end (out_is_frame_end),
    .out_payload_byte (out_payload_byte),
    .out_last_block   (out_last_block),
    .out_frame_length (out_frame_length),
    .out_status       (out_status)
  );

  // Clock: 4 high, 4 low
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Return the parser to hunting for ESC STX
  function void clear_parser();
    parse_phase   = P_HUNT_ESC;
    bytes_left    = '0;
    frame_len     = '0;
    xor_sum       = '0;
    esc_seen      = 1'b0;
    ends_with_etx = 1'b0;
  endfunction

  function void push_frame_end(input logic [2:0] st, input logic last);
    result_t r;
    r.is_frame_end = 1'b1;
    r.payload_byte = 8'h00;
    r.last_block   = last;
    r.frame_length = frame_len;
    r.status       = st;
    deframed_results.push_back(r);
    clear_parser();
  endfunction

  function void push_payload(input logic [7:0] b);
    result_t r;
    r.is_frame_end = 1'b0;
    r.payload_byte = b;
    r.last_block   = 1'b0;
    r.frame_length = frame_len;
    r.status       = ST_OK;
    deframed_results.push_back(r);
    xor_sum    = xor_sum ^ b;
    bytes_left = bytes_left - 16'd1;
    if (bytes_left == 16'd0) parse_phase = P_FOOT_ESC;
  endfunction

  // Advance the deframer by one received byte
  function void deframe_byte(input logic [7:0] b);
    case (parse_phase)
      P_HUNT_ESC: begin
        if (b != SYM_ESC) push_frame_end(ST_BAD_HDR, 1'b0);
        else parse_phase = P_HUNT_STX;
      end
      P_HUNT_STX: begin
        if (b != SYM_STX) push_frame_end(ST_BAD_HDR, 1'b0);
        else parse_phase = P_HDR_A;
      end
      P_HDR_A: begin
        xor_sum     = xor_sum ^ b;
        parse_phase = P_HDR_B;
      end
      P_HDR_B: begin
        xor_sum     = xor_sum ^ b;
        parse_phase = P_LEN_LO;
      end
      P_LEN_LO: begin
        xor_sum     = xor_sum ^ b;
        frame_len   = {8'h00, b};
        parse_phase = P_LEN_HI;
      end
      P_LEN_HI: begin
        xor_sum     = xor_sum ^ b;
        frame_len   = {b, frame_len[7:0]};
        bytes_left  = {b, frame_len[7:0]};
        parse_phase = (bytes_left == 16'd0) ? P_FOOT_ESC : P_PAYLOAD;
      end
      P_PAYLOAD: begin
        if (esc_seen) begin
          esc_seen = 1'b0;
          if (b != SYM_ESC) push_frame_end(ST_BAD_ESC, 1'b0);
          else push_payload(b);
        end else if (b == SYM_ESC) begin
          esc_seen = 1'b1;
        end else begin
          push_payload(b);
        end
      end
      P_FOOT_ESC: begin
        if (b != SYM_ESC) push_frame_end(ST_BAD_FOOT, 1'b0);
        else parse_phase = P_FOOT_TERM;
      end
      P_FOOT_TERM: begin
        if (b == SYM_ETX || b == SYM_ETB) begin
          ends_with_etx = (b == SYM_ETX);
          xor_sum       = xor_sum ^ b;
          parse_phase   = P_FOOT_CHECK;
        end else begin
          push_frame_end(ST_BAD_TERM, 1'b0);
        end
      end
      P_FOOT_CHECK: begin
        push_frame_end((b == xor_sum) ? ST_OK : ST_BAD_CHECK, ends_with_etx);
      end
      default: clear_parser();
    endcase
  endfunction

  function void compare_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endfunction

  // Predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      clear_parser();
      deframed_results.delete();
    end else begin
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
      if (out_valid && !out_stall) begin
        if (deframed_results.size() == 0) begin
          $error("result transfer with nothing expected (status %0d)", out_status);
          error_count++;
        end else begin
          exp_r = deframed_results.pop_front();
          compare_field("is_frame_end", 32'(exp_r.is_frame_end), 32'(out_is_frame_end));
          compare_field("payload_byte", 32'(exp_r.payload_byte), 32'(out_payload_byte));
          compare_field("last_block", 32'(exp_r.last_block), 32'(out_last_block));
          compare_field("frame_length", 32'(exp_r.frame_length), 32'(out_frame_length));
          compare_field("status", 32'(exp_r.status), 32'(out_status));
        end
      end
    end
  end

  // Timeout guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: long hold-off on request, otherwise a changing stall rate
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      if (stall_span == 0) begin
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
        stall_span = $urandom_range(20, 150);
      end
      stall_span--;
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  // Offer one byte and hold it until it transfers
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (idle_enable && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        in_valid   = 1'b0;
        in_rx_byte = 8'($urandom);
      end
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // Idle bytes while hunting and a wrong byte after the opening ESC
  task automatic test_idle_bytes();
    send_bytes('{8'h00, 8'hFF, SYM_ESC, SYM_ETX});
  endtask

  // Zero-length frame, last block, good checksum
  task automatic test_empty_frame();
    send_bytes('{SYM_ESC, SYM_STX, 8'h00, 8'hFF, 8'h00, 8'h00,
                 SYM_ESC, SYM_ETX, 8'hFF ^ SYM_ETX});
  endtask

  // Maximum announced length, then ESC followed by a non-ESC byte
  task automatic test_bad_escape();
    send_bytes('{SYM_ESC, SYM_STX, 8'hA5, 8'h5A, 8'hFF, 8'hFF, SYM_ESC, 8'h55});
  endtask

  // Doubled ESC in the payload, more-blocks terminator, wrong checksum
  task automatic test_escaped_payload();
    send_bytes('{SYM_ESC, SYM_STX, SYM_ESC, SYM_ETB, 8'h01, 8'h00,
                 SYM_ESC, SYM_ESC, SYM_ESC, SYM_ETB, 8'hFE});
  endtask

  // Receiver holds off while a long frame keeps coming
  task automatic test_back_pressure();
    logic [7:0] frame_q[$];
    logic [7:0] chk;
    logic [7:0] val;
    frame_q = '{SYM_ESC, SYM_STX, 8'h3C, 8'hC3, 8'd40, 8'h00};
    chk = 8'h3C ^ 8'hC3 ^ 8'd40;
    for (int i = 0; i < 40; i++) begin
      val = 8'($urandom);
      frame_q.push_back(val);
      if (val == SYM_ESC) frame_q.push_back(SYM_ESC);
      chk = chk ^ val;
    end
    frame_q.push_back(SYM_ESC);
    frame_q.push_back(SYM_ETX);
    frame_q.push_back(chk ^ SYM_ETX);
    idle_enable  = 1'b0;
    hold_request = 100;
    send_bytes(frame_q);
    idle_enable = 1'b1;
  endtask

  // Mostly well-formed frames with random content, plus noise and faults
  task automatic test_random_frames();
    logic [7:0]  frame_q[$];
    logic [7:0]  chk;
    logic [7:0]  val;
    logic [7:0]  bad;
    logic [15:0] len;
    int kind;
    int pick;
    int cut;
    int bad_at;
    int sent;
    sent = 0;
    while (sent < 1350) begin
      frame_q.delete();
      kind = $urandom_range(99);
      if (kind < 8) begin
        // line noise between frames
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
      end else begin
        frame_q.push_back(SYM_ESC);
        frame_q.push_back(SYM_STX);
        val = 8'($urandom);
        frame_q.push_back(val);
        chk = val;
        val = 8'($urandom);
        frame_q.push_back(val);
        chk = chk ^ val;
        if (kind < 14) len = 16'($urandom) | 16'h0100;
        else if (kind < 24) len = 16'd0;
        else if (kind < 34) len = 16'($urandom_range(9, 40));
        else len = 16'($urandom_range(1, 8));
        frame_q.push_back(len[7:0]);
        frame_q.push_back(len[15:8]);
        chk = chk ^ len[7:0] ^ len[15:8];
        // long frames are always cut short by a bad escape
        if (kind < 14) bad_at = $urandom_range(0, 5);
        else if (kind >= 24 && kind < 30) bad_at = $urandom_range(0, int'(len) - 1);
        else bad_at = -1;
        cut = (bad_at >= 0) ? bad_at : int'(len);
        for (int i = 0; i < cut; i++) begin
          val = ($urandom_range(5) == 0) ? SYM_ESC : 8'($urandom);
          frame_q.push_back(val);
          if (val == SYM_ESC) frame_q.push_back(SYM_ESC);
          chk = chk ^ val;
        end
        if (bad_at >= 0) begin
          bad = 8'($urandom);
          if (bad == SYM_ESC) bad = 8'h00;
          frame_q.push_back(SYM_ESC);
          frame_q.push_back(bad);
        end else begin
          pick = $urandom_range(99);
          if (pick < 5) begin
            bad = 8'($urandom);
            if (bad == SYM_ESC) bad = ~bad;
            frame_q.push_back(bad);
          end else begin
            frame_q.push_back(SYM_ESC);
            if (pick < 10) begin
              bad = 8'($urandom);
              if (bad == SYM_ETX || bad == SYM_ETB) bad = ~bad;
              frame_q.push_back(bad);
            end else begin
              val = $urandom_range(1) ? SYM_ETX : SYM_ETB;
              frame_q.push_back(val);
              chk = chk ^ val;
              if ($urandom_range(99) < 12) chk = chk ^ 8'($urandom_range(1, 255));
              frame_q.push_back(chk);
            end
          end
        end
      end
      idle_enable = ($urandom_range(9) != 0);
      send_bytes(frame_q);
      sent += frame_q.size();
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_rx_byte   = 8'h00;
    out_stall    = 1'b0;
    error_count  = 0;
    cycle_count  = 0;
    burst_left   = 0;
    idle_enable  = 1'b1;
    hold_request = 0;
    hold_left    = 0;
    stall_pct    = 0;
    stall_span   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_bytes();
    test_empty_frame();
    test_bad_escape();
    test_escaped_payload();
    test_back_pressure();
    test_random_frames();

    // Drop valid, drain, then allow for the pipeline latency
    @(negedge clk);
    in_valid = 1'b0;
    while (deframed_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (deframed_results.size() != 0) begin
      $error("%0d expected results never arrived", deframed_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/efd_pkg.sv
rtl/efd_parser.sv
rtl/efd_out_fifo.sv
rtl/escaped_frame_deframer.sv
tb/sv/tb_escaped_frame_deframer.sv
